FILE: sv/bqt_pkg.sv
// bqt_pkg: types, constants and helpers of the brace and quote tokenizer
// no dependencies; used by the interfaces, the top level and its checker
package bqt_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 12;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned KIND_W = 2;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd256;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 8'd255;

  localparam logic [KIND_W-1:0] KIND_BARE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUOTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OPEN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd3;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_OPEN = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_BARE   = 4'b0010,
    MODE_QUOTED = 4'b0100,
    MODE_ESCAPE = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  token_byte;
    logic               byte_valid;
    logic               token_end;
    logic [KIND_W-1:0]  token_kind;
    logic               too_long;
    logic [DEPTH_W-1:0] nesting_depth;
    logic               unbalanced;
  } res_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] len);
    return (len == LEN_MAX) ? len : len + 1'b1;
  endfunction

  function automatic res_t make_res(input logic [BYTE_W-1:0] b, input logic v,
                                    input logic e, input logic [KIND_W-1:0] k,
                                    input logic tl, input logic [DEPTH_W-1:0] d,
                                    input logic u);
    res_t r;
    r.token_byte = b;
    r.byte_valid = v;
    r.token_end = e;
    r.token_kind = k;
    r.too_long = tl;
    r.nesting_depth = d;
    r.unbalanced = u;
    return r;
  endfunction

endpackage

FILE: sv/bqt_if.sv
// bqt_if: request channels of the brace and quote tokenizer
// depends on bqt_pkg for field widths
interface bqt_in_if;
  logic                       valid;
  logic                       ready;
  logic [bqt_pkg::BYTE_W-1:0] char_in;
  logic                       end_of_input;
  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface bqt_out_if;
  logic                        valid;
  logic                        ready;
  logic [bqt_pkg::BYTE_W-1:0]  token_byte;
  logic                        byte_valid;
  logic                        token_end;
  logic [bqt_pkg::KIND_W-1:0]  token_kind;
  logic                        too_long;
  logic [bqt_pkg::DEPTH_W-1:0] nesting_depth;
  logic                        unbalanced;
  modport source (output valid, output token_byte, output byte_valid, output token_end,
                  output token_kind, output too_long, output nesting_depth,
                  output unbalanced, input ready);
  modport sink (input valid, input token_byte, input byte_valid, input token_end,
                input token_kind, input too_long, input nesting_depth,
                input unbalanced, output ready);
endinterface

interface bqt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bqt_pkg::LEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/brace_quote_tokenizer.sv
// brace_quote_tokenizer: top level, scanner state, result register and spill slot
// depends on bqt_pkg and the channels in bqt_if
//
// Splits a byte stream into tokens, one byte request per cycle. Each accepted
// byte is decoded in the same cycle against the scan state and yields zero, one
// or two results, which land in a result register and a one-entry spill slot.
// A new byte is taken whenever the spill slot is empty and the result register
// is empty or being drained, so plain text runs at one byte per cycle; a byte
// that yields two results (a brace that ends a word, an escaped non-quote, end
// of input after a backslash) blocks the next byte until the spill slot empties.
// The length limit register is always ready and should be written while idle.
module brace_quote_tokenizer (
  input  logic         clk,
  input  logic         rst_n,
  bqt_in_if.sink       in_if,
  bqt_out_if.source    out_if,
  bqt_cfg_if.sink      cfg_if
);

  bqt_pkg::mode_t                mode_r, mode_nxt;
  logic [bqt_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [bqt_pkg::LEN_W-1:0]     max_len_r, max_len_nxt;
  logic [bqt_pkg::DEPTH_W-1:0]   depth_r, depth_nxt;
  bqt_pkg::res_t                 out_r, out_nxt;
  bqt_pkg::res_t                 pend_r, pend_nxt;
  logic                          out_vld_r, out_vld_nxt;
  logic                          pend_vld_r, pend_vld_nxt;

  bqt_pkg::res_t                 r0, r1;
  logic                          has0, has1;
  logic [bqt_pkg::LEN_W-1:0]     len1, len2;
  logic [bqt_pkg::DEPTH_W-1:0]   brace_depth;
  logic                          brace_unb;
  logic [bqt_pkg::KIND_W-1:0]    brace_kind;
  logic                          is_brace;
  logic                          tl_cur, tl_one, tl_inc1, tl_inc2;
  logic [bqt_pkg::BYTE_W-1:0]    c;
  logic                          take_out, acc;

  assign c = in_if.char_in;
  assign take_out = out_vld_r && out_if.ready;
  assign in_if.ready = !pend_vld_r && (!out_vld_r || out_if.ready);
  assign acc = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign len1 = bqt_pkg::len_inc(len_r);
  assign len2 = bqt_pkg::len_inc(len1);
  assign tl_cur = len_r >= max_len_r;
  assign tl_one = {{(bqt_pkg::LEN_W-1){1'b0}}, 1'b1} >= max_len_r;
  assign tl_inc1 = len1 >= max_len_r;
  assign tl_inc2 = len2 >= max_len_r;

  // brace token: depth after it and underbalance
  always_comb begin
    is_brace = (c == bqt_pkg::CH_OPEN) || (c == bqt_pkg::CH_CLOSE);
    brace_unb = 1'b0;
    brace_depth = depth_r;
    if (c == bqt_pkg::CH_OPEN) begin
      brace_kind = bqt_pkg::KIND_OPEN;
      if (depth_r < bqt_pkg::DEPTH_LIMIT) begin
        brace_depth = depth_r + 1'b1;
      end
    end else begin
      brace_kind = bqt_pkg::KIND_CLOSE;
      if (depth_r == '0) begin
        brace_unb = 1'b1;
      end else begin
        brace_depth = depth_r - 1'b1;
      end
    end
  end

  // decode of one byte request
  always_comb begin
    r0 = bqt_pkg::make_res('0, 1'b0, 1'b1, bqt_pkg::KIND_BARE, tl_cur, depth_r, 1'b0);
    r1 = r0;
    has0 = 1'b0;
    has1 = 1'b0;
    mode_nxt = mode_r;
    len_nxt = len_r;
    depth_nxt = depth_r;
    if (in_if.end_of_input) begin
      mode_nxt = bqt_pkg::MODE_IDLE;
      len_nxt = '0;
      unique case (mode_r)
        bqt_pkg::MODE_BARE: begin
          has0 = 1'b1;
        end
        bqt_pkg::MODE_QUOTED: begin
          has0 = 1'b1;
          r0.token_kind = bqt_pkg::KIND_QUOTED;
        end
        bqt_pkg::MODE_ESCAPE: begin
          has0 = 1'b1;
          has1 = 1'b1;
          r0 = bqt_pkg::make_res(bqt_pkg::CH_BACKSLASH, 1'b1, 1'b0, bqt_pkg::KIND_QUOTED,
                                 tl_inc1, depth_r, 1'b0);
          r1 = bqt_pkg::make_res('0, 1'b0, 1'b1, bqt_pkg::KIND_QUOTED,
                                 tl_inc1, depth_r, 1'b0);
        end
        default: begin
        end
      endcase
    end else begin
      unique case (mode_r)
        bqt_pkg::MODE_IDLE: begin
          if (bqt_pkg::is_blank(c)) begin
          end else if (c == bqt_pkg::CH_QUOTE) begin
            len_nxt = '0;
            mode_nxt = bqt_pkg::MODE_QUOTED;
          end else if (is_brace) begin
            has0 = 1'b1;
            r0 = bqt_pkg::make_res(c, 1'b1, 1'b1, brace_kind, tl_one, brace_depth, brace_unb);
            depth_nxt = brace_depth;
            len_nxt = '0;
          end else begin
            has0 = 1'b1;
            r0 = bqt_pkg::make_res(c, 1'b1, 1'b0, bqt_pkg::KIND_BARE, tl_one, depth_r, 1'b0);
            len_nxt = {{(bqt_pkg::LEN_W-1){1'b0}}, 1'b1};
            mode_nxt = bqt_pkg::MODE_BARE;
          end
        end
        bqt_pkg::MODE_BARE: begin
          has0 = 1'b1;
          if (bqt_pkg::is_blank(c)) begin
            len_nxt = '0;
            mode_nxt = bqt_pkg::MODE_IDLE;
          end else if (is_brace) begin
            has1 = 1'b1;
            r1 = bqt_pkg::make_res(c, 1'b1, 1'b1, brace_kind, tl_one, brace_depth, brace_unb);
            depth_nxt = brace_depth;
            len_nxt = '0;
            mode_nxt = bqt_pkg::MODE_IDLE;
          end else begin
            r0 = bqt_pkg::make_res(c, 1'b1, 1'b0, bqt_pkg::KIND_BARE, tl_inc1, depth_r, 1'b0);
            len_nxt = len1;
          end
        end
        bqt_pkg::MODE_QUOTED: begin
          if (c == bqt_pkg::CH_QUOTE) begin
            has0 = 1'b1;
            r0.token_kind = bqt_pkg::KIND_QUOTED;
            len_nxt = '0;
            mode_nxt = bqt_pkg::MODE_IDLE;
          end else if (c == bqt_pkg::CH_BACKSLASH) begin
            mode_nxt = bqt_pkg::MODE_ESCAPE;
          end else begin
            has0 = 1'b1;
            r0 = bqt_pkg::make_res(c, 1'b1, 1'b0, bqt_pkg::KIND_QUOTED, tl_inc1, depth_r, 1'b0);
            len_nxt = len1;
          end
        end
        bqt_pkg::MODE_ESCAPE: begin
          has0 = 1'b1;
          mode_nxt = bqt_pkg::MODE_QUOTED;
          if (c == bqt_pkg::CH_QUOTE) begin
            r0 = bqt_pkg::make_res(c, 1'b1, 1'b0, bqt_pkg::KIND_QUOTED, tl_inc1, depth_r, 1'b0);
            len_nxt = len1;
          end else begin
            has1 = 1'b1;
            r0 = bqt_pkg::make_res(bqt_pkg::CH_BACKSLASH, 1'b1, 1'b0, bqt_pkg::KIND_QUOTED,
                                   tl_inc1, depth_r, 1'b0);
            r1 = bqt_pkg::make_res(c, 1'b1, 1'b0, bqt_pkg::KIND_QUOTED, tl_inc2, depth_r, 1'b0);
            len_nxt = len2;
          end
        end
        default: begin
          mode_nxt = bqt_pkg::MODE_IDLE;
        end
      endcase
    end
  end

  // result register and spill slot
  always_comb begin
    out_nxt = out_r;
    pend_nxt = pend_r;
    out_vld_nxt = out_vld_r;
    pend_vld_nxt = pend_vld_r;
    max_len_nxt = max_len_r;
    if (cfg_if.valid) begin
      max_len_nxt = cfg_if.data;
    end
    if (acc && has0) begin
      out_nxt = r0;
      out_vld_nxt = 1'b1;
      pend_nxt = r1;
      pend_vld_nxt = has1;
    end else if (take_out) begin
      out_nxt = pend_r;
      out_vld_nxt = pend_vld_r;
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bqt_pkg::MODE_IDLE;
      len_r <= '0;
      depth_r <= '0;
      max_len_r <= bqt_pkg::MAX_LEN_RESET;
      out_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt;
        len_r <= len_nxt;
        depth_r <= depth_nxt;
      end
      max_len_r <= max_len_nxt;
      out_vld_r <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_if.valid = out_vld_r;
  assign out_if.token_byte = out_r.token_byte;
  assign out_if.byte_valid = out_r.byte_valid;
  assign out_if.token_end = out_r.token_end;
  assign out_if.token_kind = out_r.token_kind;
  assign out_if.too_long = out_r.too_long;
  assign out_if.nesting_depth = out_r.nesting_depth;
  assign out_if.unbalanced = out_r.unbalanced;

endmodule

FILE: sv/bqt_checker.sv
// bqt_checker: port-level assertions for the brace and quote tokenizer
// depends on bqt_pkg; bound to brace_quote_tokenizer below
module bqt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bqt_pkg::BYTE_W-1:0]  out_token_byte,
  input logic                        out_byte_valid,
  input logic                        out_token_end,
  input logic [bqt_pkg::KIND_W-1:0]  out_token_kind,
  input logic [bqt_pkg::DEPTH_W-1:0] out_nesting_depth,
  input logic                        out_unbalanced
);

  // stalled result request stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // underbalance only on a close brace left at depth zero
  a_unbalanced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unbalanced |->
      out_token_kind == bqt_pkg::KIND_CLOSE && out_nesting_depth == '0)
    else $error("underbalance flag on a wrong result");

  // bare end marker carries a zero byte and closes the token
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_token_end && out_token_byte == '0)
    else $error("malformed end marker");

  // braces are one-byte tokens
  a_brace_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == bqt_pkg::KIND_OPEN ||
                  out_token_kind == bqt_pkg::KIND_CLOSE) |->
      out_token_end && out_byte_valid &&
      (out_token_byte == bqt_pkg::CH_OPEN || out_token_byte == bqt_pkg::CH_CLOSE))
    else $error("brace token not a single closing byte");

endmodule

bind brace_quote_tokenizer bqt_checker u_bqt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_token_byte    (out_if.token_byte),
  .out_byte_valid    (out_if.byte_valid),
  .out_token_end     (out_if.token_end),
  .out_token_kind    (out_if.token_kind),
  .out_nesting_depth (out_if.nesting_depth),
  .out_unbalanced    (out_if.unbalanced)
);
